// ----- src/sem_pkg.sv -----
// Package for the Sobel edge magnitude unit: widths, register indexes, limits.
// No dependencies.
package sem_pkg;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int CFG_ADDR_W    = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_HEIGHT = 3'd4;
    localparam logic [12:0] WIDTH_RESET  = 13'd4096;
    localparam logic [15:0] HEIGHT_RESET = 16'd4096;
    // Sum of squares is at most 2*1020^2 < 2^21
    localparam int SQ_W  = 21;
    localparam int RES_W = 11;

    // One pending result: window columns and rows that feed it.
    typedef struct packed {
        logic [7:0] t0, t1, t2;
        logic [7:0] m0, m2;
        logic [7:0] b0, b1, b2;
        logic       last;
        logic       eof;
    } sem_job_t;
endpackage

// ----- src/sem_sqrt_cell.sv -----
// One cell of the bit-serial square-root chain: one result bit per cell.
// Depends on sem_pkg.
module sem_sqrt_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [sem_pkg::SQ_W-1:0]  in_rem,
    input  logic [sem_pkg::SQ_W-1:0]  in_root,
    input  logic [sem_pkg::SQ_W-1:0]  bit_val,
    input  logic [1:0]                in_tag,
    output logic                      out_valid,
    output logic [sem_pkg::SQ_W-1:0]  out_rem,
    output logic [sem_pkg::SQ_W-1:0]  out_root,
    output logic [1:0]                out_tag
);
    import sem_pkg::*;
    logic [SQ_W-1:0]  trial;
    logic [SQ_W-1:0]  rem_next;
    logic [SQ_W-1:0]  root_next;
    logic [SQ_W-1:0]  root_w;

    // Try subtracting root+bit; shift the root either way
    always_comb
    begin
        root_w = in_root;
        trial  = root_w + bit_val;
        if (in_rem >= trial)
        begin
            rem_next  = in_rem - trial;
            root_next = (root_w >> 1) + bit_val;
        end
        else
        begin
            rem_next  = in_rem;
            root_next = in_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        out_rem  <= rem_next;
        out_root <= root_next;
        out_tag  <= in_tag;
    end
endmodule

// ----- src/sobel_edge_magnitude_unit.sv -----
// Top level of the Sobel edge magnitude unit: line buffers, window, result queue,
// gradient stage, square-root cells and output fifo. Depends on sem_pkg, sem_sqrt_cell.
//
// Channel | Signals                                         | Role
// in      | in_valid in_ready pixel                         | pixel requests
// out     | out_valid out_ready edge_magnitude last_in_run end_of_frame | results
// cfg     | psel penable pwrite paddr pwdata prdata pready  | APB registers
//
// Each pixel makes 0 to 4 results and is issued one result per cycle while the output fifo
// has room; a pixel making n results holds the input through its line read and n issues.
// Each result passes the line read, window, gradient register, 11 sqrt cells and output
// fifo in that order, behind the earlier results of its pixel.
// in_ready drops the cycle after each accept and while jobs remain, as on a fifo stall.
// Reset clears counters and the window; line buffers need no clearing pass.
module sobel_edge_magnitude_unit
#(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      edge_magnitude,
    output logic                            last_in_run,
    output logic                            end_of_frame,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sem_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import sem_pkg::*;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = AW + 1;
    localparam int NCELL = RES_W;
    localparam int QD    = 4;
    localparam int FD    = 16;   // output fifo depth, above pipeline length
    localparam int FW    = $clog2(FD);

    // ---------------- configuration ----------------
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr)
            ADDR_WIDTH:  prdata = {19'd0, width_reg};
            ADDR_HEIGHT: prdata = {16'd0, height_reg};
            default:     prdata = 32'd0;
        endcase
    end

    logic [CW-1:0] w_eff;
    logic [15:0]   h_eff;
    always_comb
    begin
        if (width_reg == 13'd0)
            w_eff = CW'(1);
        else if ({19'd0, width_reg} > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
    end

    // ---------------- stage 0: line buffer read ----------------
    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;
    logic [7:0]    upper_mem [MAX_WIDTH];
    logic [7:0]    middle_mem [MAX_WIDTH];
    logic [7:0]    up_rd, mid_rd;
    logic          s1_valid_reg;
    logic [7:0]    s1_pix;
    logic [CW-1:0] s1_col;
    logic [15:0]   s1_row;
    logic          s1_lastc, s1_lastr;
    logic          accept;
    logic [CW-1:0] c_cur;
    logic [15:0]   r_cur;
    logic [AW-1:0] c_idx;

    assign c_cur  = (col_reg >= w_eff) ? CW'(0) : col_reg;
    assign r_cur  = (row_reg >= h_eff) ? 16'd0 : row_reg;
    assign c_idx  = c_cur[AW-1:0];
    assign accept = in_valid && in_ready;

    // Read old rows, shift pixel into the middle line
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd             <= upper_mem[c_idx];
            mid_rd            <= middle_mem[c_idx];
            middle_mem[c_idx] <= pixel;
            s1_pix            <= pixel;
            s1_col            <= c_cur;
            s1_row            <= r_cur;
            s1_lastc          <= (c_cur == w_eff - CW'(1));
            s1_lastr          <= (r_cur == h_eff - 16'd1);
        end
    end

    // Move the old middle row into the upper line
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            upper_mem[s1_col[AW-1:0]] <= mid_rd;
    end

    // Take register writes, which restart the frame, and advance counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg_wr && (paddr == ADDR_WIDTH || paddr == ADDR_HEIGHT))
            begin
                if (paddr == ADDR_WIDTH)
                    width_reg <= pwdata[12:0];
                else
                    height_reg <= pwdata[15:0];
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (c_cur == w_eff - CW'(1))
                begin
                    col_reg <= '0;
                    row_reg <= (r_cur == h_eff - 16'd1) ? 16'd0 : r_cur + 16'd1;
                end
                else
                    col_reg <= c_cur + CW'(1);
            end
        end
    end

    // ---------------- stage 1: window and job build ----------------
    logic [7:0] win_reg [12];
    logic [7:0] win_next [12];
    logic [7:0] v [3];

    always_comb
    begin
        v[0] = up_rd;
        v[1] = mid_rd;
        v[2] = s1_pix;
        for (int rr = 0; rr < 3; rr++)
        begin
            for (int k = 0; k < 3; k++)
                win_next[rr*4+k] = (s1_col == CW'(0)) ? v[rr] : win_reg[rr*4+k+1];
            win_next[rr*4+3] = v[rr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
                win_reg[i] <= 8'd0;
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 12; i++)
                win_reg[i] <= win_next[i];
        end
    end

    function automatic sem_job_t mk_job(input logic [7:0] w [12], input int tr,
                                        input int mr, input int k0, input int k1,
                                        input int k2, input logic eof);
        sem_job_t j;
        j.t0 = w[tr*4+k0]; j.t1 = w[tr*4+k1]; j.t2 = w[tr*4+k2];
        j.m0 = w[mr*4+k0]; j.m2 = w[mr*4+k2];
        j.b0 = w[8+k0];    j.b1 = w[8+k1];    j.b2 = w[8+k2];
        j.last = 1'b0;
        j.eof  = eof;
        return j;
    endfunction

    sem_job_t   jobs [QD];
    logic [QD-1:0] jv;
    always_comb
    begin
        int tra, trb;
        tra = (s1_row >= 16'd2) ? 0 : 1;
        trb = (s1_row >= 16'd1) ? 1 : 2;
        jobs[0] = mk_job(win_next, tra, 1, 1, 2, 3, 1'b0);
        jobs[1] = mk_job(win_next, tra, 1, 2, 3, 3, 1'b0);
        jobs[2] = mk_job(win_next, trb, 2, 1, 2, 3, 1'b0);
        jobs[3] = mk_job(win_next, trb, 2, 2, 3, 3, 1'b1);
        jv[0] = (s1_row != 16'd0) && (s1_col != CW'(0));
        jv[1] = (s1_row != 16'd0) && s1_lastc;
        jv[2] = s1_lastr && (s1_col != CW'(0));
        jv[3] = s1_lastr && s1_lastc;
        if (jv[3])      jobs[3].last = 1'b1;
        else if (jv[2]) jobs[2].last = 1'b1;
        else if (jv[1]) jobs[1].last = 1'b1;
        else            jobs[0].last = 1'b1;
    end

    // Hold pending jobs; issue one per cycle while the fifo has room
    sem_job_t      q_reg [QD];
    logic [QD-1:0] qv_reg;
    logic [QD-1:0] qv_after;
    logic          issue;
    sem_job_t      iss_job;
    logic          room;

    always_comb
    begin
        issue   = 1'b0;
        iss_job = q_reg[0];
        qv_after = qv_reg;
        for (int i = QD-1; i >= 0; i--)
        begin
            if (qv_reg[i])
            begin
                iss_job = q_reg[i];
            end
        end
        if ((qv_reg != '0) && room)
        begin
            issue = 1'b1;
            for (int i = 0; i < QD; i++)
            begin
                if (qv_reg[i] && (qv_after == qv_reg))
                    qv_after[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            for (int i = 0; i < QD; i++)
                q_reg[i] <= jobs[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qv_reg <= '0;
        else if (s1_valid_reg)
            qv_reg <= jv;
        else
            qv_reg <= qv_after;
    end

    // ---------------- stage 2: gradients and sum of squares ----------------
    logic signed [11:0] gx, gy;
    logic [SQ_W-1:0]    sq;
    logic               g_valid_reg;
    logic [SQ_W-1:0]    g_sq_reg;
    logic [1:0]         g_tag_reg;
    always_comb
    begin
        gx = 12'(signed'({4'd0, iss_job.t0})) - 12'(signed'({4'd0, iss_job.t2}))
           + 12'(signed'({3'd0, iss_job.m0, 1'b0})) - 12'(signed'({3'd0, iss_job.m2, 1'b0}))
           + 12'(signed'({4'd0, iss_job.b0})) - 12'(signed'({4'd0, iss_job.b2}));
        gy = 12'(signed'({4'd0, iss_job.t0})) + 12'(signed'({3'd0, iss_job.t1, 1'b0}))
           + 12'(signed'({4'd0, iss_job.t2})) - 12'(signed'({4'd0, iss_job.b0}))
           - 12'(signed'({3'd0, iss_job.b1, 1'b0})) - 12'(signed'({4'd0, iss_job.b2}));
    end
    logic [21:0] sq_w;
    assign sq_w = 22'(gx * gx) + 22'(gy * gy);
    assign sq   = sq_w[SQ_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else
            g_valid_reg <= issue;
    end
    always_ff @(posedge clk)
    begin
        g_sq_reg  <= sq;
        g_tag_reg <= {iss_job.last, iss_job.eof};
    end

    // ---------------- square-root cell chain ----------------
    logic                 cv   [NCELL+1];
    logic [SQ_W-1:0]      crem [NCELL+1];
    logic [SQ_W-1:0]      croot[NCELL+1];
    logic [1:0]           ctag [NCELL+1];
    assign cv[0]    = g_valid_reg;
    assign crem[0]  = g_sq_reg;
    assign croot[0] = '0;
    assign ctag[0]  = g_tag_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            sem_sqrt_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_valid (cv[gi]),
                .in_rem   (crem[gi]),
                .in_root  (croot[gi]),
                .bit_val  (SQ_W'(1) << (2*(NCELL-1-gi))),
                .in_tag   (ctag[gi]),
                .out_valid(cv[gi+1]),
                .out_rem  (crem[gi+1]),
                .out_root (croot[gi+1]),
                .out_tag  (ctag[gi+1])
            );
        end
    endgenerate

    // ---------------- output fifo ----------------
    logic [9:0]  fifo_mem [FD];
    logic [FW-1:0] wp_reg, rp_reg;
    logic [FW:0]   cnt_reg;
    logic [FW:0]   infl_reg;   // results issued, not yet in fifo
    logic [7:0]    mag;
    logic          pop;

    assign mag  = (croot[NCELL] > SQ_W'(255)) ? 8'd255 : croot[NCELL][7:0];
    assign pop  = out_valid && out_ready;
    assign room = (cnt_reg + infl_reg) < (FW+1)'(FD - 1);
    assign in_ready = (qv_reg == '0 || (qv_after == '0 && issue)) && !s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cv[NCELL])
            fifo_mem[wp_reg] <= {mag, ctag[NCELL]};
    end

    assign {edge_magnitude, last_in_run, end_of_frame} = fifo_mem[rp_reg];
    assign out_valid = (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            infl_reg <= '0;
        end
        else
        begin
            if (cv[NCELL])
                wp_reg <= wp_reg + FW'(1);
            if (pop)
                rp_reg <= rp_reg + FW'(1);
            cnt_reg  <= cnt_reg + (FW+1)'(cv[NCELL]) - (FW+1)'(pop);
            infl_reg <= infl_reg + (FW+1)'(issue) - (FW+1)'(cv[NCELL]);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cv[NCELL] |-> cnt_reg < (FW+1)'(FD))
        else $error("result fifo overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("result fifo underflow");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (qv_reg == '0) || (qv_after == '0 && issue))
        else $error("pending jobs overwritten");
`endif
endmodule

// ----- tb/sobel_edge_magnitude_unit_test.sv -----
// Testbench for the Sobel edge magnitude unit: a class predicts results from
// the pixel stream and register writes; tasks drive pixels and APB.
// Depends on sem_pkg and sobel_edge_magnitude_unit.
`timescale 1ns / 1ps

class sobel_scoreboard;
    typedef struct {
        logic [7:0] mag;
        logic       last;
        logic       eof;
    } edge_result_t;

    logic [7:0]   upper_line [4096];
    logic [7:0]   middle_line [4096];
    logic [7:0]   win [12];
    int unsigned  col, row, wid, hgt;
    edge_result_t owed [$];
    int           errors;
    int           results_seen;

    function void clear();
        foreach (upper_line[i]) upper_line[i] = '0;
        foreach (middle_line[i]) middle_line[i] = '0;
        foreach (win[i]) win[i] = '0;
        col = 0;
        row = 0;
        wid = 4096;
        hgt = 4096;
        errors = 0;
        results_seen = 0;
    endfunction

    // Register writes restart the frame; line contents stay
    function void write_reg(logic [2:0] addr, logic [31:0] data);
        if (addr == sem_pkg::ADDR_WIDTH)
            wid = data[12:0];
        else
            hgt = data[15:0];
        col = 0;
        row = 0;
    endfunction

    function logic [7:0] grad(int tr, int mr, int br, int k0, int k1, int k2);
        int gx, gy, s, r;
        gx = (int'(win[tr*4+k0]) - int'(win[tr*4+k2]))
           + 2 * (int'(win[mr*4+k0]) - int'(win[mr*4+k2]))
           + (int'(win[br*4+k0]) - int'(win[br*4+k2]));
        gy = (int'(win[tr*4+k0]) + 2 * int'(win[tr*4+k1]) + int'(win[tr*4+k2]))
           - (int'(win[br*4+k0]) + 2 * int'(win[br*4+k1]) + int'(win[br*4+k2]));
        s = gx * gx + gy * gy;
        if (s >= 255 * 255)
            return 8'd255;
        r = 0;
        while ((r + 1) * (r + 1) <= s)
            r++;
        return r[7:0];
    endfunction

    function void push(logic [7:0] mag, logic eof);
        edge_result_t e;
        e.mag = mag;
        e.last = 1'b0;
        e.eof = eof;
        owed.push_back(e);
    endfunction

    // Advance line buffers and window by one pixel, queue the owed results
    function void note_pixel(logic [7:0] px);
        int unsigned w, h, c, r;
        logic [7:0] v [3];
        int n0, tr;
        bit last_col, last_row;
        w = (wid == 0) ? 1 : ((wid > 4096) ? 4096 : wid);
        h = (hgt == 0) ? 1 : hgt;
        if (col >= w) col = 0;
        if (row >= h) row = 0;
        c = col;
        r = row;
        v[0] = upper_line[c];
        v[1] = middle_line[c];
        v[2] = px;
        upper_line[c] = v[1];
        middle_line[c] = v[2];
        for (int i = 0; i < 3; i++)
        begin
            if (c == 0)
            begin
                for (int k = 0; k < 4; k++) win[i*4+k] = v[i];
            end
            else
            begin
                for (int k = 0; k < 3; k++) win[i*4+k] = win[i*4+k+1];
                win[i*4+3] = v[i];
            end
        end
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        n0 = owed.size();
        if (r >= 1)
        begin
            tr = (r >= 2) ? 0 : 1;
            if (c >= 1) push(grad(tr, 1, 2, 1, 2, 3), 1'b0);
            if (last_col) push(grad(tr, 1, 2, 2, 3, 3), 1'b0);
        end
        if (last_row)
        begin
            tr = (r >= 1) ? 1 : 2;
            if (c >= 1) push(grad(tr, 2, 2, 1, 2, 3), 1'b0);
            if (last_col) push(grad(tr, 2, 2, 2, 3, 3), 1'b1);
        end
        if (owed.size() > n0) owed[owed.size()-1].last = 1'b1;
        if (last_col)
        begin
            col = 0;
            row = last_row ? 0 : r + 1;
        end
        else
            col = c + 1;
    endfunction

    function void check_result(logic [7:0] mag, logic last, logic eof);
        edge_result_t e;
        results_seen++;
        if (owed.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: mag %0d last %0b eof %0b", mag, last, eof);
            return;
        end
        e = owed.pop_front();
        if (e.mag !== mag || e.last !== last || e.eof !== eof)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected mag %0d last %0b eof %0b, got %0d %0b %0b",
                         e.mag, e.last, e.eof, mag, last, eof);
        end
    endfunction
endclass

module sobel_edge_magnitude_unit_test;
    import sem_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pixel;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  edge_magnitude;
    logic        last_in_run;
    logic        end_of_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sobel_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quiet_cycles;
    int pixels_sent;
    int phases_run;

    sobel_edge_magnitude_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .edge_magnitude(edge_magnitude), .last_in_run(last_in_run),
        .end_of_frame(end_of_frame),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Result side: check accepted results, then choose next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(edge_magnitude, last_in_run, end_of_frame);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results owed", board.owed.size());
            $display("sobel_edge_magnitude_unit_test failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every owed result is back and the pipeline is quiet
    task automatic drain();
        drop_valid();
        while (board.owed.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.write_reg(addr, data);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        drain();
        write_reg(ADDR_WIDTH, w);
        write_reg(ADDR_HEIGHT, h);
        phases_run++;
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        int w, h, n;
        board = new();
        board.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        pixels_sent = 0;
        phases_run = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: top row of a tall frame gives nothing yet
        for (int i = 0; i < 3; i++) send_pixel(8'(i * 85));
        // Single pixel frames: one result each, marking frame end
        set_frame(1, 1);
        send_pixel(8'd0);
        send_pixel(8'd255);
        // Checkerboard 3x3 saturates the magnitude
        set_frame(3, 3);
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
        // Width above the line size folds to the maximum
        set_frame(8191, 1);
        for (int i = 0; i < 5; i++) send_pixel(i[0] ? 8'hAA : 8'h55);
        // Zero width and height act as one
        set_frame(0, 0);
        send_pixel(8'd17);
        send_pixel(8'd200);
        // Tallest frame, a few rows of a narrow image
        set_frame(4, 65535);
        for (int i = 0; i < 12; i++) send_pixel(pick_pixel());

        // Random frames over the idling phases
        while (pixels_sent < 160)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 10);
            h = $urandom_range(1, 6);
            set_frame(w, h);
            case (phases_run % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 55; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            n = (w > 64) ? $urandom_range(1, 20) : w * h * $urandom_range(1, 2)
                + $urandom_range(w);
            for (int i = 0; i < n; i++) send_pixel(pick_pixel());
        end

        // Long receiver hold while pixels keep coming, so the unit backs up
        set_frame(1, 2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 40; i++) send_pixel(pick_pixel());
        // Pause sender until all owed results are back, then resume
        drain();
        for (int i = 0; i < 10; i++) send_pixel(pick_pixel());

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d pixels over %0d frame settings, %0d results checked",
                 pixels_sent, phases_run, board.results_seen);
        $display("including saturated, clamped-border and frame-end results");
        if (board.errors == 0)
            $display("sobel_edge_magnitude_unit_test passed");
        else
        begin
            $display("%0d mismatches", board.errors);
            $display("sobel_edge_magnitude_unit_test failed");
        end
        $finish;
    end
endmodule
